>>> sv/bsmt_pkg.sv
// shared types and constants of the backing store map table
package bsmt_pkg;

    localparam int NUM_STORES = 16;
    localparam int NUM_PROCS  = 64;
    localparam int MAX_PAGES  = 128;

    localparam logic [1:0] ACT_GET_FREE = 2'd0;
    localparam logic [1:0] ACT_FREE     = 2'd1;
    localparam logic [1:0] ACT_LOOKUP   = 2'd2;
    localparam logic [1:0] ACT_MAP      = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  pid;
        logic [19:0] page;
        logic [3:0]  sid;
        logic [19:0] base;
        logic [7:0]  npg;
        logic        wr;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic       hit;
        logic [3:0] store;
        logic [6:0] offset;
    } link_t;

endpackage

>>> sv/bsmt_cell.sv
// one store cell: flags, page count, per-process entries and search stage
module bsmt_cell #(
    parameter logic [3:0] IDX = 4'd0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  bsmt_pkg::cmd_t  cmd,
    input  bsmt_pkg::link_t link_in,
    output bsmt_pkg::link_t link_out
);

    logic                            in_use_reg;
    logic [7:0]                      pages_reg;
    logic [bsmt_pkg::NUM_PROCS-1:0]  valid_reg;
    logic [19:0]                     mem [0:bsmt_pkg::NUM_PROCS-1];
    logic [19:0]                     rd_reg;
    bsmt_pkg::link_t                 link_reg;
    bsmt_pkg::link_t                 link_next;

    logic        sel;
    logic        mine;
    logic [20:0] hi;
    logic [19:0] diff;

    assign sel  = (cmd.sid == IDX);
    assign hi   = {1'b0, rd_reg} + {13'd0, pages_reg};
    assign diff = cmd.page - rd_reg;

    always_comb begin
        mine = 1'b0;
        case (cmd.action)
            bsmt_pkg::ACT_GET_FREE: mine = !in_use_reg;
            bsmt_pkg::ACT_LOOKUP: begin
                mine = valid_reg[cmd.pid] && (cmd.page >= rd_reg)
                       && ({1'b0, cmd.page} < hi);
            end
            default: mine = 1'b0;
        endcase
        link_next = link_in;
        if (link_in.valid && !link_in.hit && mine) begin
            link_next.hit   = 1'b1;
            link_next.store = IDX;
            link_next.offset = (cmd.action == bsmt_pkg::ACT_LOOKUP) ? diff[6:0] : 7'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr && sel && cmd.action == bsmt_pkg::ACT_MAP) begin
            mem[cmd.pid] <= cmd.base;
        end
        rd_reg <= mem[cmd.pid];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= 1'b0;
            pages_reg  <= 8'd0;
            valid_reg  <= '0;
            link_reg   <= '0;
        end else begin
            link_reg <= link_next;
            if (cmd.wr && sel) begin
                if (cmd.action == bsmt_pkg::ACT_MAP) begin
                    in_use_reg          <= 1'b1;
                    pages_reg           <= cmd.npg;
                    valid_reg[cmd.pid]  <= 1'b1;
                end else begin
                    in_use_reg <= 1'b0;
                    pages_reg  <= 8'd0;
                    valid_reg  <= '0;
                end
            end
        end
    end

    assign link_out = link_reg;

endmodule

>>> sv/backing_store_map_table.sv
// top level of the backing store map table: control and chain of store cells
//
// channel  | ports                                              | dir
// request  | s_valid s_ready s_action s_proc_id s_virt_addr ... | in
// result   | m_valid m_ready m_ok m_found_store m_page_offset   | out
//
// free and map are checked in the EXEC state and go straight to DONE; get free and
// lookup launch a search through the chain, one register per store cell.
// one request at a time; s_ready is low from accept until the result is
// loaded into the output register, which holds it while m_ready is low.
// synchronous reset clears all flags, page counts and valid bits at once.
module backing_store_map_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [5:0]  s_proc_id,
    input  logic [31:0] s_virt_addr,
    input  logic [3:0]  s_store_id,
    input  logic [19:0] s_base_vpage,
    input  logic [7:0]  s_num_pages,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [3:0]  m_found_store,
    output logic [6:0]  m_page_offset
);

    typedef enum logic [1:0] {IDLE, EXEC, SEARCH, DONE} state_t;

    state_t          state_reg;
    bsmt_pkg::cmd_t  req_reg;
    bsmt_pkg::cmd_t  cmd;
    bsmt_pkg::link_t launch_reg;
    bsmt_pkg::link_t chain [0:bsmt_pkg::NUM_STORES];
    logic            res_ok_reg;
    logic [3:0]      res_store_reg;
    logic [6:0]      res_off_reg;
    logic            m_valid_reg;
    logic            m_ok_reg;
    logic [3:0]      m_store_reg;
    logic [6:0]      m_off_reg;
    logic            map_ok;
    logic            sid_ok;

    assign sid_ok = ({28'd0, req_reg.sid} < 32'(bsmt_pkg::NUM_STORES))
                    && ({26'd0, req_reg.pid} < 32'(bsmt_pkg::NUM_PROCS) ||
                        req_reg.action == bsmt_pkg::ACT_FREE);
    assign map_ok = (req_reg.npg != 8'd0)
                    && ({24'd0, req_reg.npg} <= 32'(bsmt_pkg::MAX_PAGES)) && sid_ok;

    always_comb begin
        cmd    = req_reg;
        cmd.wr = 1'b0;
        if (state_reg == EXEC) begin
            if (req_reg.action == bsmt_pkg::ACT_MAP) begin
                cmd.wr = map_ok;
            end else if (req_reg.action == bsmt_pkg::ACT_FREE) begin
                cmd.wr = sid_ok;
            end
        end
    end

    assign chain[0] = launch_reg;

    for (genvar i = 0; i < bsmt_pkg::NUM_STORES; i++) begin : g_cell
        bsmt_cell #(.IDX(4'(i))) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .link_in  (chain[i]),
            .link_out (chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            launch_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        req_reg.action <= s_action;
                        req_reg.pid    <= s_proc_id;
                        req_reg.page   <= s_virt_addr[31:12];
                        req_reg.sid    <= s_store_id;
                        req_reg.base   <= s_base_vpage;
                        req_reg.npg    <= s_num_pages;
                        req_reg.wr     <= 1'b0;
                        state_reg      <= EXEC;
                    end
                end
                EXEC: begin
                    if (req_reg.action == bsmt_pkg::ACT_MAP) begin
                        res_ok_reg    <= map_ok;
                        res_store_reg <= 4'd0;
                        res_off_reg   <= 7'd0;
                        state_reg     <= DONE;
                    end else if (req_reg.action == bsmt_pkg::ACT_FREE) begin
                        res_ok_reg    <= sid_ok;
                        res_store_reg <= 4'd0;
                        res_off_reg   <= 7'd0;
                        state_reg     <= DONE;
                    end else begin
                        launch_reg.valid <= 1'b1;
                        state_reg        <= SEARCH;
                    end
                end
                SEARCH: begin
                    launch_reg <= '0;
                    if (chain[bsmt_pkg::NUM_STORES].valid) begin
                        res_ok_reg    <= chain[bsmt_pkg::NUM_STORES].hit;
                        res_store_reg <= chain[bsmt_pkg::NUM_STORES].store;
                        res_off_reg   <= chain[bsmt_pkg::NUM_STORES].offset;
                        state_reg     <= DONE;
                    end
                end
                DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_ok_reg    <= res_ok_reg;
                        m_store_reg <= res_store_reg;
                        m_off_reg   <= res_off_reg;
                        state_reg   <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == IDLE);
    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_found_store = m_store_reg;
    assign m_page_offset = m_off_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_found_store) && $stable(m_ok)))
        else $error("result dropped while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_found_store == 4'd0 && m_page_offset == 7'd0))
        else $error("nonzero fields on error result");

endmodule

>>> tb/bsmt_checker.sv
// checker: watches both channels, predicts map table results and compares them
module bsmt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [5:0]  s_proc_id,
    input  logic [31:0] s_virt_addr,
    input  logic [3:0]  s_store_id,
    input  logic [19:0] s_base_vpage,
    input  logic [7:0]  s_num_pages,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_ok,
    input  logic [3:0]  m_found_store,
    input  logic [6:0]  m_page_offset,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic       ok;
        logic [3:0] store;
        logic [6:0] offset;
    } answer_t;

    logic        in_use  [bsmt_pkg::NUM_STORES];
    logic [7:0]  npages  [bsmt_pkg::NUM_STORES];
    logic        owned   [bsmt_pkg::NUM_STORES][bsmt_pkg::NUM_PROCS];
    logic [19:0] base_pg [bsmt_pkg::NUM_STORES][bsmt_pkg::NUM_PROCS];
    answer_t     answers [$];

    function automatic void release_store(input int s);
        in_use[s] = 1'b0;
        npages[s] = '0;
        for (int p = 0; p < bsmt_pkg::NUM_PROCS; p++) begin
            owned[s][p] = 1'b0;
            base_pg[s][p] = 20'd4096;
        end
    endfunction

    function automatic answer_t table_result(input logic [1:0] act, input logic [5:0] pid,
            input logic [31:0] addr, input logic [3:0] sid, input logic [19:0] bp,
            input logic [7:0] np);
        answer_t a;
        logic [19:0] pg;
        logic [20:0] hi;
        a = '0;
        pg = addr[31:12];
        case (act)
            bsmt_pkg::ACT_GET_FREE: begin
                for (int s = bsmt_pkg::NUM_STORES - 1; s >= 0; s--)
                    if (!in_use[s]) begin
                        a.ok = 1'b1;
                        a.store = s[3:0];
                    end
            end
            bsmt_pkg::ACT_FREE: begin
                release_store(sid);
                a.ok = 1'b1;
            end
            bsmt_pkg::ACT_LOOKUP: begin
                for (int s = bsmt_pkg::NUM_STORES - 1; s >= 0; s--) begin
                    hi = {1'b0, base_pg[s][pid]} + npages[s];
                    if (owned[s][pid] && pg >= base_pg[s][pid] && {1'b0, pg} < hi) begin
                        a.ok = 1'b1;
                        a.store = s[3:0];
                        a.offset = 7'(pg - base_pg[s][pid]);
                    end
                end
            end
            default: begin
                if (np >= 1 && np <= bsmt_pkg::MAX_PAGES) begin
                    in_use[sid] = 1'b1;
                    npages[sid] = np;
                    owned[sid][pid] = 1'b1;
                    base_pg[sid][pid] = bp;
                    a.ok = 1'b1;
                end
            end
        endcase
        return a;
    endfunction

    initial begin
        fail_count = 0;
        for (int s = 0; s < bsmt_pkg::NUM_STORES; s++) release_store(s);
    end

    assign pending = answers.size();

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && s_valid && s_ready)
            answers.push_back(table_result(s_action, s_proc_id, s_virt_addr, s_store_id,
                s_base_vpage, s_num_pages));
        if (aresetn && m_valid && m_ready) begin
            if (answers.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result ok=%0d", m_ok);
            end else begin
                want = answers.pop_front();
                if (want != {m_ok, m_found_store, m_page_offset}) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected ok=%0d store=%0d off=%0d, got %0d %0d %0d",
                            want.ok, want.store, want.offset, m_ok, m_found_store,
                            m_page_offset);
                end
            end
        end
    end

endmodule

>>> tb/tb.sv
// testbench top: request stimulus, result stalls, watchdog and verdict
module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [5:0]  s_proc_id = '0;
    logic [31:0] s_virt_addr = '0;
    logic [3:0]  s_store_id = '0;
    logic [19:0] s_base_vpage = '0;
    logic [7:0]  s_num_pages = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ok;
    logic [3:0]  m_found_store;
    logic [6:0]  m_page_offset;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic [19:0] hot_base [4];

    backing_store_map_table u_top (.*);

    bsmt_checker u_chk (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver stall pattern: phases of no stall, light and heavy stalls
    always @(posedge aclk) begin
        int mode;
        mode = int'(($time / 4000) % 3);
        if (mode == 0) m_ready <= 1'b1;
        else if (mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge aclk) begin
        if (s_valid && s_ready || m_valid && m_ready) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [5:0] pid,
            input logic [31:0] addr, input logic [3:0] sid, input logic [19:0] bp,
            input logic [7:0] np);
        s_valid <= 1'b1;
        s_action <= act;
        s_proc_id <= pid;
        s_virt_addr <= addr;
        s_store_id <= sid;
        s_base_vpage <= bp;
        s_num_pages <= np;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic pause_sender();
        if ($urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic random_request();
        logic [1:0]  act;
        logic [3:0]  sid;
        logic [19:0] bp;
        int          k;
        act = 2'($urandom_range(0, 3));
        k = $urandom_range(0, 3);
        sid = 4'($urandom);
        bp = ($urandom_range(0, 3) == 0) ? 20'($urandom) : hot_base[k];
        if (act == bsmt_pkg::ACT_FREE && $urandom_range(0, 2) != 0) act = bsmt_pkg::ACT_LOOKUP;
        send_request(act, 6'($urandom_range(0, 7)) | (($urandom_range(0, 5) == 0) ?
            6'($urandom) : 6'd0),
            {20'(hot_base[k] + $urandom_range(0, 140)), 12'($urandom)} ^
            (($urandom_range(0, 7) == 0) ? $urandom : 32'd0),
            sid, bp, ($urandom_range(0, 9) == 0) ? 8'($urandom) :
            8'($urandom_range(1, 128)));
    endtask

    initial begin
        int burst;
        int done;
        hot_base[0] = 20'd0;
        hot_base[1] = 20'd4096;
        hot_base[2] = 20'hfff80;
        hot_base[3] = 20'($urandom);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: empty table, edge page counts, extremes, wrap at top of space
        send_request(bsmt_pkg::ACT_GET_FREE, 6'd0, 32'd0, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd0, 32'h0100_0000, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_MAP, 6'd0, 32'd0, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_MAP, 6'd0, 32'd0, 4'd0, 20'd0, 8'd129);
        send_request(bsmt_pkg::ACT_MAP, 6'd0, 32'd0, 4'd0, 20'd0, 8'd255);
        send_request(bsmt_pkg::ACT_MAP, 6'd63, 32'd0, 4'd15, 20'hfffff, 8'd128);
        send_request(bsmt_pkg::ACT_MAP, 6'd0, 32'd0, 4'd0, 20'd0, 8'd1);
        send_request(bsmt_pkg::ACT_GET_FREE, 6'd0, 32'd0, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd63, 32'hffff_ffff, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd0, 32'h0000_0fff, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd0, 32'h0000_1000, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_MAP, 6'd5, 32'd0, 4'd3, 20'h00100, 8'd128);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd5, 32'h0017_f000, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd5, 32'h0018_0000, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_MAP, 6'd5, 32'd0, 4'd3, 20'h00100, 8'd16);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd5, 32'h0011_0000, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd4, 32'h0010_0000, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_FREE, 6'd0, 32'd0, 4'd15, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd63, 32'hffff_f000, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_FREE, 6'd0, 32'd0, 4'd0, 20'd0, 8'd0);
        for (int s = 0; s < bsmt_pkg::NUM_STORES; s++)
            send_request(bsmt_pkg::ACT_MAP, 6'd1, 32'd0, 4'(s), 20'(s * 8), 8'd8);
        send_request(bsmt_pkg::ACT_GET_FREE, 6'd0, 32'd0, 4'd0, 20'd0, 8'd0);
        send_request(bsmt_pkg::ACT_LOOKUP, 6'd1, 32'h0007_f000, 4'd0, 20'd0, 8'd0);
        // random part in bursts
        done = 0;
        while (done < 1620) begin
            burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            for (int i = 0; i < burst; i++) random_request();
            done += burst;
            pause_sender();
        end
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

>>> backing_store_map_table.f
sv/bsmt_pkg.sv
sv/bsmt_cell.sv
sv/backing_store_map_table.sv
tb/bsmt_checker.sv
tb/tb.sv
